// File: design/ilb_pkg.sv
package ilb_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int WORD_WIDTH_DEF = 32;

	// Field widths of the request and response beats
	localparam int MODE_W  = 3;
	localparam int INDEX_W = 5;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 2;

	localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

	// Command broadcast from the controller to every cell
	typedef struct packed {
		logic wr;     // load the new word into the cell at pos
		logic shift;  // cells above pos take their lower neighbor's word
	} ilb_cmd_t;

endpackage

// File: design/ilb_req_if.sv
interface ilb_req_if;
	import ilb_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [INDEX_W-1:0] index;
	logic [VALUE_W-1:0] value;

	modport source (output valid, mode, index, value, input ready);
	modport sink   (input valid, mode, index, value, output ready);
endinterface

// File: design/ilb_rsp_if.sv
interface ilb_rsp_if;
	import ilb_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] read_value;
	logic [COUNT_W-1:0] count;
	logic [STAT_W-1:0]  status;

	modport source (output valid, read_value, count, status, input ready);
	modport sink   (input valid, read_value, count, status, output ready);
endinterface

// File: design/ilb_cell.sv
module ilb_cell #(
	parameter int WORD_WIDTH = 32,
	parameter int IW         = 5,
	parameter int POS        = 0
) (
	input  logic                  clk,
	input  ilb_pkg::ilb_cmd_t     cmd,
	input  logic [IW-1:0]         pos,
	input  logic [WORD_WIDTH-1:0] din,
	input  logic [WORD_WIDTH-1:0] lower,
	output logic [WORD_WIDTH-1:0] word
);
	import ilb_pkg::*;

	localparam logic [IW-1:0] MY_POS = IW'(POS);

	logic [WORD_WIDTH-1:0] word_q;

	// Load at own position, or take the lower neighbor's word when an insert lands below
	always_ff @(posedge clk) begin
		if (cmd.wr && pos == MY_POS) begin
			word_q <= din;
		end else if (cmd.shift && MY_POS > pos) begin
			word_q <= lower;
		end
	end

	assign word = word_q;
endmodule

// File: design/ilb_ctrl.sv
module ilb_ctrl #(
	parameter int DEPTH = 16,
	parameter int CNT_W = 5,
	parameter int IW    = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [ilb_pkg::MODE_W-1:0] mode,
	input  logic [IW-1:0]              idx,
	output ilb_pkg::ilb_cmd_t          cmd,
	output logic [IW-1:0]              pos,
	output logic                       rd_hit,
	output logic [ilb_pkg::STAT_W-1:0] status,
	output logic [CNT_W-1:0]           count_next
);
	import ilb_pkg::*;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0] count_q;
	logic [IW-1:0]    cnt_w;
	logic             in_range;
	logic             ins_range;
	logic             full;
	logic             empty;

	assign cnt_w     = IW'(count_q);
	assign in_range  = idx < cnt_w;
	assign ins_range = idx <= cnt_w;
	assign full      = count_q == FULL_CNT;
	assign empty     = count_q == '0;

	always_comb begin
		cmd        = '0;
		pos        = idx;
		rd_hit     = 1'b0;
		status     = ST_OK;
		count_next = count_q;
		unique case (mode)
			MODE_PUSH: begin
				pos = cnt_w;
				if (full) begin
					status = ST_FULL;
				end else begin
					cmd.wr     = 1'b1;
					count_next = count_q + CNT_W'(1);
				end
			end
			MODE_POP: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_next = count_q - CNT_W'(1);
				end
			end
			MODE_WRITE: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					cmd.wr = 1'b1;
				end
			end
			MODE_READ: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					rd_hit = 1'b1;
				end
			end
			MODE_INSERT: begin
				if (!ins_range) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					cmd.wr     = 1'b1;
					cmd.shift  = 1'b1;
					count_next = count_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
		// Drop all effects unless a beat is taken this cycle
		if (!go) begin
			cmd = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (go) begin
			count_q <= count_next;
		end
	end
endmodule

// File: design/indexed_list_buffer.sv
// indexed_list_buffer: an ordered list of up to DEPTH words of WORD_WIDTH
// bits. Each request beat carries a mode (push at end, pop from end, write
// at index, read at index, insert at index) with an index and a value, and
// produces exactly one response beat holding the word read (zero unless a
// read succeeds), the entry count after the operation and a status (ok,
// index out of range, full, empty). Failed operations change nothing. The
// words live in a row of DEPTH cells; an insert moves every entry at or
// above the index up one cell in the same clock, and a new request is
// accepted every cycle as long as the response register is empty or
// being drained. The response is registered and appears in the cycle after
// the request is taken. No clearing pass follows reset: only the count is
// cleared, and entries become readable only once written.
module indexed_list_buffer #(
	parameter int DEPTH      = ilb_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = ilb_pkg::WORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ilb_req_if.sink   req,
	ilb_rsp_if.source rsp
);
	import ilb_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = $clog2(DEPTH);
	localparam int IW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

	logic                  go;
	ilb_cmd_t              cmd;
	logic [IW-1:0]         idx;
	logic [IW-1:0]         pos;
	logic                  rd_hit;
	logic [STAT_W-1:0]     status;
	logic [CNT_W-1:0]      count_next;
	logic [WORD_WIDTH+VALUE_W-1:0] val_x;
	logic [WORD_WIDTH-1:0] din;
	logic [WORD_WIDTH-1:0] words [DEPTH];
	logic [WORD_WIDTH-1:0] rd_word;
	logic [WORD_WIDTH+VALUE_W-1:0] rd_x;
	logic [CNT_W+COUNT_W-1:0]      cnt_x;

	// Response register
	logic               rsp_valid_q;
	logic [VALUE_W-1:0] rsp_value_q;
	logic [COUNT_W-1:0] rsp_count_q;
	logic [STAT_W-1:0]  rsp_status_q;

	// Take a beat whenever the response slot is free or draining
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign go        = req.valid && req.ready;

	assign idx   = IW'(req.index);
	assign val_x = (WORD_WIDTH + VALUE_W)'(req.value);
	assign din   = val_x[WORD_WIDTH-1:0];

	ilb_ctrl #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W),
		.IW    (IW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.mode       (req.mode),
		.idx        (idx),
		.cmd        (cmd),
		.pos        (pos),
		.rd_hit     (rd_hit),
		.status     (status),
		.count_next (count_next)
	);

	// Row of cells; on insert each cell at or above the index hands its word to the cell above
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [WORD_WIDTH-1:0] lower;
		if (g == 0) begin : g_first
			assign lower = '0;
		end else begin : g_rest
			assign lower = words[g-1];
		end
		ilb_cell #(
			.WORD_WIDTH (WORD_WIDTH),
			.IW         (IW),
			.POS        (g)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.pos   (pos),
			.din   (din),
			.lower (lower),
			.word  (words[g])
		);
	end

	// A read hit implies the index is below DEPTH, so the low bits select the cell
	assign rd_word = rd_hit ? words[idx[CW-1:0]] : '0;
	assign rd_x    = (WORD_WIDTH + VALUE_W)'(rd_word);
	assign cnt_x   = (CNT_W + COUNT_W)'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Hold the payload while the response stalls
	always_ff @(posedge clk) begin
		if (go) begin
			rsp_value_q  <= rd_x[VALUE_W-1:0];
			rsp_count_q  <= cnt_x[COUNT_W-1:0];
			rsp_status_q <= status;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.count      = rsp_count_q;
	assign rsp.status     = rsp_status_q;
endmodule

// File: design/ilb_checker.sv
module ilb_checker #(
	parameter int DEPTH = ilb_pkg::DEPTH_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [ilb_pkg::VALUE_W-1:0] rsp_read_value,
	input logic [ilb_pkg::COUNT_W-1:0] rsp_count,
	input logic [ilb_pkg::STAT_W-1:0]  rsp_status
);
	import ilb_pkg::*;

	localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);
	// The count field only bounds the list when the capacity fits in it
	localparam bit CNT_FITS = DEPTH < (2 ** COUNT_W);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
		else $error("failed operation returned a nonzero word");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0)
		else $error("empty status with nonzero count");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_count == FULL_CNT)
		else $error("full status with count below capacity");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && CNT_FITS |-> rsp_count <= FULL_CNT)
		else $error("count above capacity");
endmodule

bind indexed_list_buffer ilb_checker #(
	.DEPTH (DEPTH)
) u_ilb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value),
	.rsp_count      (rsp.count),
	.rsp_status     (rsp.status)
);
